// ----- rtl/circular_list_engine_unit_assert.svh -----
// Assertion macros for the RTL of the circular list engine.
`ifndef CIRCULAR_LIST_ENGINE_UNIT_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular list check failed");

// Next-cycle implication, checked outside reset.
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular list check failed");

`endif

// ----- rtl/cle_pkg.sv -----
package cle_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_FIRST     = 3'd2,
    MODE_NEXT      = 3'd3,
    MODE_REMOVE    = 3'd4
  } cle_mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_NOCUR = 2'd3
  } cle_status_t;

  typedef struct packed {
    logic [2:0]                     mode;
    logic signed [DATA_WIDTH-1:0]   value;
  } cle_req_t;

  typedef struct packed {
    cle_status_t                    status;
    logic signed [DATA_WIDTH-1:0]   value_out;
    logic [CNT_W-1:0]               count;
  } cle_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic finish;
  } cle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
  } cle_stat_t;

endpackage

// ----- rtl/cle_ctrl.sv -----
module cle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cle_pkg::cle_stat_t  stat,
  output cle_pkg::cle_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_EXEC   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          // rejected or unused requests go straight to the result
          state_next  = stat.skip ? S_FINISH : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/cle_dpath.sv -----
module cle_dpath (
  input  logic               clk,
  input  logic               rst,
  input  cle_pkg::cle_cmd_t  cmd,
  input  cle_pkg::cle_req_t  request,
  output cle_pkg::cle_stat_t stat,
  output logic               done,
  output cle_pkg::cle_rsp_t  result
);

  // list storage
  logic [cle_pkg::DATA_WIDTH-1:0] node_values [cle_pkg::CAPACITY];
  logic [cle_pkg::IDX_W-1:0]      node_links  [cle_pkg::CAPACITY];
  logic [cle_pkg::IDX_W-1:0]      free_stack  [cle_pkg::CAPACITY];

  logic [cle_pkg::CNT_W-1:0] free_top, free_top_next;
  logic [cle_pkg::CNT_W-1:0] entry_count, entry_count_next;
  logic [cle_pkg::IDX_W-1:0] tail_ptr, tail_ptr_next;
  logic                      tail_valid, tail_valid_next;
  logic [cle_pkg::IDX_W-1:0] cursor_ptr, cursor_ptr_next;
  logic [cle_pkg::IDX_W-1:0] prior_ptr, prior_ptr_next;
  logic                      cursor_valid, cursor_valid_next;
  logic                      remove_ready, remove_ready_next;

  // per-request registers
  logic [2:0]                     mode_q;
  logic [cle_pkg::DATA_WIDTH-1:0] value_q;
  cle_pkg::cle_status_t           status_q;
  logic                           skip_q;
  logic [cle_pkg::IDX_W-1:0]      node_q;
  logic [cle_pkg::IDX_W-1:0]      link_q;
  logic [cle_pkg::DATA_WIDTH-1:0] rdval_q;

  cle_pkg::cle_status_t      stat_code;
  logic                      is_insert, is_read;
  logic                      remove_last;
  logic [cle_pkg::CNT_W-1:0] top_less;
  logic [cle_pkg::IDX_W-1:0] top_idx;
  logic                      push_ok;
  logic [cle_pkg::IDX_W-1:0] link_raddr;
  logic [cle_pkg::IDX_W-1:0] val_raddr;
  logic                      link_we;
  logic [cle_pkg::IDX_W-1:0] link_waddr, link_wdata;
  logic                      val_we;

  // request check against the current list state
  always_comb begin
    stat_code = cle_pkg::STAT_OK;
    unique case (request.mode) inside
      cle_pkg::MODE_INS_FRONT, cle_pkg::MODE_INS_BACK: begin
        if (free_top == '0) stat_code = cle_pkg::STAT_FULL;
      end
      cle_pkg::MODE_FIRST: begin
        if (!tail_valid) stat_code = cle_pkg::STAT_EMPTY;
      end
      cle_pkg::MODE_NEXT: begin
        if (!tail_valid)        stat_code = cle_pkg::STAT_EMPTY;
        else if (!cursor_valid) stat_code = cle_pkg::STAT_NOCUR;
      end
      cle_pkg::MODE_REMOVE: begin
        if (!tail_valid)                         stat_code = cle_pkg::STAT_EMPTY;
        else if (!cursor_valid || !remove_ready) stat_code = cle_pkg::STAT_NOCUR;
      end
      default: stat_code = cle_pkg::STAT_OK;
    endcase
    stat.skip = (stat_code != cle_pkg::STAT_OK) || (request.mode > cle_pkg::MODE_REMOVE);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= request.mode;
      value_q  <= request.value;
      status_q <= stat_code;
      skip_q   <= stat.skip;
    end
  end

  assign is_insert = (mode_q == cle_pkg::MODE_INS_FRONT) || (mode_q == cle_pkg::MODE_INS_BACK);
  assign is_read   = (mode_q == cle_pkg::MODE_FIRST) || (mode_q == cle_pkg::MODE_NEXT) ||
                     (mode_q == cle_pkg::MODE_REMOVE);

  assign top_less = free_top - 1'b1;
  assign top_idx  = top_less[cle_pkg::IDX_W-1:0];
  assign push_ok  = (free_top < cle_pkg::CNT_W'(cle_pkg::CAPACITY));

  assign link_raddr = (is_insert || (mode_q == cle_pkg::MODE_FIRST)) ? tail_ptr : cursor_ptr;
  assign val_raddr  = (mode_q == cle_pkg::MODE_REMOVE) ? cursor_ptr : link_q;

  assign remove_last = (entry_count <= cle_pkg::CNT_W'(1)) || (link_q == cursor_ptr);

  // single link write port: new node's link in exec, neighbor's link in finish
  always_comb begin
    link_we    = 1'b0;
    link_waddr = node_q;
    link_wdata = tail_valid ? link_q : node_q;
    val_we     = 1'b0;
    if (cmd.exec && is_insert) begin
      link_we = 1'b1;
      val_we  = 1'b1;
    end else if (cmd.finish && !skip_q) begin
      if (is_insert && tail_valid) begin
        link_we    = 1'b1;
        link_waddr = tail_ptr;
        link_wdata = node_q;
      end else if ((mode_q == cle_pkg::MODE_REMOVE) && !remove_last) begin
        link_we    = 1'b1;
        link_waddr = prior_ptr;
        link_wdata = link_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) node_links[link_waddr] <= link_wdata;
    if (cmd.lookup) begin
      link_q <= node_links[link_raddr];
      node_q <= free_stack[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) node_values[node_q] <= value_q;
    if (cmd.exec) rdval_q <= node_values[val_raddr];
  end

  // list state update at the end of a request
  always_comb begin
    free_top_next     = free_top;
    entry_count_next  = entry_count;
    tail_ptr_next     = tail_ptr;
    tail_valid_next   = tail_valid;
    cursor_ptr_next   = cursor_ptr;
    prior_ptr_next    = prior_ptr;
    cursor_valid_next = cursor_valid;
    remove_ready_next = remove_ready;
    if (cmd.finish && !skip_q) begin
      unique case (mode_q) inside
        cle_pkg::MODE_INS_FRONT, cle_pkg::MODE_INS_BACK: begin
          free_top_next     = top_less;
          entry_count_next  = entry_count + 1'b1;
          tail_valid_next   = 1'b1;
          if (!tail_valid || (mode_q == cle_pkg::MODE_INS_BACK)) tail_ptr_next = node_q;
          remove_ready_next = 1'b0;
        end
        cle_pkg::MODE_FIRST: begin
          prior_ptr_next    = tail_ptr;
          cursor_ptr_next   = link_q;
          cursor_valid_next = 1'b1;
          remove_ready_next = 1'b1;
        end
        cle_pkg::MODE_NEXT: begin
          prior_ptr_next    = cursor_ptr;
          cursor_ptr_next   = link_q;
          remove_ready_next = 1'b1;
        end
        cle_pkg::MODE_REMOVE: begin
          if (remove_last) begin
            tail_valid_next   = 1'b0;
            cursor_valid_next = 1'b0;
            tail_ptr_next     = '0;
            cursor_ptr_next   = '0;
            prior_ptr_next    = '0;
          end else begin
            if (cursor_ptr == tail_ptr) tail_ptr_next = prior_ptr;
            cursor_ptr_next = prior_ptr;
          end
          remove_ready_next = 1'b0;
          if (push_ok) free_top_next = free_top + 1'b1;
          if (entry_count != '0) entry_count_next = entry_count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top     <= cle_pkg::CNT_W'(cle_pkg::CAPACITY);
      entry_count  <= '0;
      tail_ptr     <= '0;
      tail_valid   <= 1'b0;
      cursor_ptr   <= '0;
      prior_ptr    <= '0;
      cursor_valid <= 1'b0;
      remove_ready <= 1'b0;
    end else begin
      free_top     <= free_top_next;
      entry_count  <= entry_count_next;
      tail_ptr     <= tail_ptr_next;
      tail_valid   <= tail_valid_next;
      cursor_ptr   <= cursor_ptr_next;
      prior_ptr    <= prior_ptr_next;
      cursor_valid <= cursor_valid_next;
      remove_ready <= remove_ready_next;
    end
  end

  // free stack starts out holding every node index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cle_pkg::CAPACITY; i++) begin
        free_stack[i] <= cle_pkg::IDX_W'(i);
      end
    end else if (cmd.finish && !skip_q && (mode_q == cle_pkg::MODE_REMOVE) && push_ok) begin
      free_stack[free_top[cle_pkg::IDX_W-1:0]] <= cursor_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status    <= status_q;
      result.value_out <= (!skip_q && is_read) ? rdval_q : '0;
      result.count     <= entry_count_next;
    end
  end

endmodule

// ----- rtl/circular_list_engine_unit.sv -----
// Circular singly linked list engine over a 16-node pool with a free stack.
// Request channel: drive request (mode, value) and raise start; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the request's work is done.
// Result channel: done is high for exactly one cycle with result (status,
// value_out, count) valid in that cycle; the receiver cannot stall it and
// must take it then.
// Sequence: after capture a list operation walks the lookup, exec and finish
// states, and its result is registered from finish; a rejected request or
// an unused mode skips from capture to finish.
// No new request is taken until the last one is finished (busy); the link
// read and the dependent node value read each go through a registered
// memory port. A new request may be taken in the cycle done is up.
// Reset (synchronous, rst high): list empty, cursor invalid, all nodes free,
// no result pending. Node storage needs no clearing.
`include "circular_list_engine_unit_assert.svh"

module circular_list_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cle_pkg::cle_req_t request,
  output logic              busy,
  output logic              done,
  output cle_pkg::cle_rsp_t result
);

  cle_pkg::cle_cmd_t  cmd;
  cle_pkg::cle_stat_t stat;

  cle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cle_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

  `CLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CLE_ASSERT_NEXT(a_finish_done, cmd.finish, done && !busy)
  `CLE_ASSERT_NOW(a_count_range, done, result.count <= cle_pkg::CNT_W'(cle_pkg::CAPACITY))
  `CLE_ASSERT_NOW(a_one_phase, 1'b1, $onehot0({cmd.capture, cmd.lookup, cmd.exec, cmd.finish}))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import cle_pkg::*;

  localparam int PHASE_ITEMS = 335;
  localparam int SHOWN_MAX   = 10;
  localparam int TAIL_CYCLES = 10;

  // codes outside the defined operations
  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  cle_req_t request = '0;
  logic     busy;
  logic     done;
  cle_rsp_t result;

  circular_list_engine_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // shadow copy of the node pool and list pointers
  logic [DATA_WIDTH-1:0] node_val  [CAPACITY];
  logic [IDX_W-1:0]      node_next [CAPACITY];
  logic [IDX_W-1:0]      free_stk  [CAPACITY];
  logic [CNT_W-1:0]      free_top;
  logic [IDX_W-1:0]      tail_idx;
  logic [IDX_W-1:0]      cur_idx;
  logic [IDX_W-1:0]      prev_idx;
  logic                  tail_ok;
  logic                  cur_ok;
  logic                  rm_armed;
  logic [CNT_W-1:0]      elem_cnt;

  cle_req_t req_backlog  [$];
  cle_rsp_t rsp_expected [$];
  int       n_queued = 0;
  int       n_issued = 0;
  int       n_taken  = 0;
  int       n_bad    = 0;
  int       idle_pct = 0;
  logic     hold_off = 1'b0;

  function automatic void list_clear();
    for (int i = 0; i < CAPACITY; i++) begin
      free_stk[i] = i[IDX_W-1:0];
    end
    free_top = CAPACITY[CNT_W-1:0];
    tail_idx = '0;
    cur_idx  = '0;
    prev_idx = '0;
    tail_ok  = 1'b0;
    cur_ok   = 1'b0;
    rm_armed = 1'b0;
    elem_cnt = '0;
  endfunction

  function automatic cle_rsp_t list_apply(input cle_req_t req);
    cle_rsp_t         rsp;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] gone;
    rsp.status    = STAT_OK;
    rsp.value_out = '0;
    case (req.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (free_top == 0) begin
          rsp.status = STAT_FULL;
        end else begin
          free_top = free_top - 1'b1;
          slot = free_stk[free_top[IDX_W-1:0]];
          node_val[slot] = req.value;
          if (!tail_ok) begin
            node_next[slot] = slot;
            tail_idx = slot;
            tail_ok = 1'b1;
          end else begin
            node_next[slot] = node_next[tail_idx];
            node_next[tail_idx] = slot;
            if (req.mode == MODE_INS_BACK) tail_idx = slot;
          end
          elem_cnt = elem_cnt + 1'b1;
          rm_armed = 1'b0;
        end
      end
      MODE_FIRST: begin
        if (!tail_ok) begin
          rsp.status = STAT_EMPTY;
        end else begin
          prev_idx = tail_idx;
          cur_idx = node_next[tail_idx];
          cur_ok = 1'b1;
          rm_armed = 1'b1;
          rsp.value_out = node_val[cur_idx];
        end
      end
      MODE_NEXT: begin
        if (!tail_ok) begin
          rsp.status = STAT_EMPTY;
        end else if (!cur_ok) begin
          rsp.status = STAT_NOCUR;
        end else begin
          prev_idx = cur_idx;
          cur_idx = node_next[cur_idx];
          rm_armed = 1'b1;
          rsp.value_out = node_val[cur_idx];
        end
      end
      MODE_REMOVE: begin
        if (!tail_ok) begin
          rsp.status = STAT_EMPTY;
        end else if (!cur_ok || !rm_armed) begin
          rsp.status = STAT_NOCUR;
        end else begin
          gone = cur_idx;
          rsp.value_out = node_val[gone];
          if (elem_cnt <= 1 || node_next[gone] == gone) begin
            tail_ok  = 1'b0;
            cur_ok   = 1'b0;
            tail_idx = '0;
            cur_idx  = '0;
            prev_idx = '0;
          end else begin
            // cursor steps back; tail follows if it was the one unlinked
            if (gone == tail_idx) tail_idx = prev_idx;
            node_next[prev_idx] = node_next[gone];
            cur_idx = prev_idx;
          end
          rm_armed = 1'b0;
          free_stk[free_top[IDX_W-1:0]] = gone;
          free_top = free_top + 1'b1;
          elem_cnt = elem_cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.count = elem_cnt;
    return rsp;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || n_taken == n_issued) begin
      if (!hold_off && req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        request <= req_backlog.pop_front();
        start <= 1'b1;
        n_issued <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor; also predicts on each accepted request
  always @(posedge clk) begin
    cle_rsp_t want;
    if (rst) begin
      list_clear();
      rsp_expected.delete();
    end else begin
      if (done) begin
        if (rsp_expected.size() == 0) begin
          n_bad++;
          if (n_bad <= SHOWN_MAX)
            $display("%0t: result with nothing outstanding: status %0d value_out %0h count %0d",
                     $time, result.status, result.value_out, result.count);
        end else begin
          want = rsp_expected.pop_front();
          if (result.status !== want.status || result.value_out !== want.value_out ||
              result.count !== want.count) begin
            n_bad++;
            if (n_bad <= SHOWN_MAX)
              $display("%0t: mismatch exp status %0d value_out %0h count %0d, got %0d %0h %0d",
                       $time, want.status, want.value_out, want.count,
                       result.status, result.value_out, result.count);
          end
        end
      end
      if (start && !busy) begin
        rsp_expected.push_back(list_apply(request));
        n_taken++;
      end
    end
  end

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    case ($urandom_range(9))
      0:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic [2:0] m, input logic [DATA_WIDTH-1:0] v);
    cle_req_t r;
    r.mode  = m;
    r.value = v;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  task automatic add_fill();
    repeat ($urandom_range(20, 17))
      push_item($urandom_range(1) ? MODE_INS_BACK : MODE_INS_FRONT, rand_value());
  endtask

  task automatic add_burst();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // walk a few nodes, then unlink the one under the cursor
        push_item($urandom_range(1) ? MODE_FIRST : MODE_NEXT, $urandom);
        repeat ($urandom_range(3)) push_item(MODE_NEXT, $urandom);
        push_item(MODE_REMOVE, $urandom);
      end
      4, 5: begin
        repeat ($urandom_range(4, 1))
          push_item($urandom_range(1) ? MODE_INS_BACK : MODE_INS_FRONT, rand_value());
      end
      6: add_fill();
      7: begin
        push_item(MODE_FIRST, $urandom);
        push_item(MODE_REMOVE, $urandom);
        repeat ($urandom_range(18, 6)) begin
          push_item(MODE_NEXT, $urandom);
          push_item(MODE_REMOVE, $urandom);
        end
      end
      default: begin
        repeat ($urandom_range(3, 1)) push_item(3'($urandom_range(7)), $urandom);
      end
    endcase
  endtask

  task automatic wait_settled();
    @(negedge clk);
    while (n_taken != n_queued || rsp_expected.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int pct);
    int ph_end;
    int pause_at;
    @(posedge clk);
    idle_pct = pct;
    ph_end   = n_queued + PHASE_ITEMS;
    pause_at = n_queued + PHASE_ITEMS / 2;
    add_fill();
    while (n_queued < ph_end) add_burst();
    // mid-phase: stop sending until the engine has answered everything
    @(negedge clk);
    while (n_taken < pause_at) @(negedge clk);
    @(posedge clk);
    hold_off = 1'b1;
    @(negedge clk);
    while (n_taken != n_issued || rsp_expected.size() != 0) @(negedge clk);
    @(posedge clk);
    hold_off = 1'b0;
    wait_settled();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    push_item(MODE_FIRST, '0);
    push_item(MODE_NEXT, '0);
    push_item(MODE_REMOVE, '0);
    push_item(MODE_RSVD_A, '1);
    push_item(MODE_RSVD_C, '0);
    push_item(MODE_INS_FRONT, 32'h7fff_ffff);
    push_item(MODE_NEXT, '0);         // no cursor yet
    push_item(MODE_REMOVE, '0);
    push_item(MODE_INS_BACK, 32'h8000_0000);
    push_item(MODE_FIRST, '0);
    push_item(MODE_INS_FRONT, '1);    // insert disarms remove
    push_item(MODE_REMOVE, '0);
    push_item(MODE_NEXT, '0);
    push_item(MODE_REMOVE, '0);       // unlinks the tail
    push_item(MODE_NEXT, '0);         // wraps to head
    push_item(MODE_REMOVE, '0);
    push_item(MODE_INS_BACK, 32'h0000_0001);
    push_item(MODE_NEXT, '0);
    push_item(MODE_NEXT, '0);
    push_item(MODE_REMOVE, '0);
    push_item(MODE_FIRST, '0);
    push_item(MODE_REMOVE, '0);       // last element goes, list empty
    push_item(MODE_NEXT, '0);
    push_item(MODE_RSVD_B, 32'h5a5a_a5a5);
    wait_settled();
    run_phase(0);
    run_phase(64);
    run_phase(0);
    run_phase(35);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
